FILE: hdl/bpf_pkg.sv
// Shared types and constants of the bus packet framer.
`timescale 1ns / 1ps
`default_nettype none

package bpf_pkg;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Work kinds handed from front to back
   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_DATA,
      KIND_REJECT
   } kind_type;

   // One classified item as queued for the serializer
   typedef struct packed {
      kind_type    kind;
      logic        close;       // emit checksum after this item
      logic [7:0]  device_id;
      logic [7:0]  source_id;
      logic [7:0]  packet_command;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } desc_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic push_ready;
      logic pop_valid;
   } qstat_type;

endpackage

`default_nettype wire

FILE: hdl/bpf_front.sv
// Front end: accepts items, tracks packet state and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module bpf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [7:0]         req_device_id,
   input  wire logic [7:0]         req_source_id,
   input  wire logic [7:0]         req_packet_command,
   input  wire logic [15:0]        req_payload_length,
   input  wire logic [7:0]         req_data_byte,
   input  wire bpf_pkg::qstat_type q_stat,
   output logic                    push,
   output bpf_pkg::desc_type       push_desc
);
   import bpf_pkg::*;

   logic        open_ff, open_in;
   logic [15:0] left_ff, left_in;
   logic        take;

   // Stall only when the queue has no room
   assign req_stall = !q_stat.push_ready;
   assign take      = req_valid && q_stat.push_ready;
   assign push      = take;

   // Classify the item and work out the next packet state
   always_comb begin
      open_in                  = open_ff;
      left_in                  = left_ff;
      push_desc.device_id      = req_device_id;
      push_desc.source_id      = req_source_id;
      push_desc.packet_command = req_packet_command;
      push_desc.payload_length = req_payload_length;
      push_desc.data_byte      = req_data_byte;
      push_desc.kind           = KIND_HEADER;
      push_desc.close          = 1'b0;
      if (!req_command) begin
         push_desc.kind  = KIND_HEADER;
         push_desc.close = (req_payload_length == 16'd0);
         open_in         = (req_payload_length != 16'd0);
         left_in         = req_payload_length;
      end else if (open_ff) begin
         push_desc.kind  = KIND_DATA;
         push_desc.close = (left_ff == 16'd1);
         left_in         = left_ff - 16'd1;
         open_in         = (left_ff != 16'd1);
      end else begin
         push_desc.kind  = KIND_REJECT;
      end
   end

   // Update packet state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 16'd0;
      end else if (take) begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bpf_queue.sv
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module bpf_queue #(
   parameter int DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bpf_pkg::desc_type push_desc,
   input  wire logic              pop,
   output bpf_pkg::desc_type      head_desc,
   output bpf_pkg::qstat_type     q_stat
);
   import bpf_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   desc_type         slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign q_stat.push_ready = (count_ff != FULL_CNT);
   assign q_stat.pop_valid  = (count_ff != '0);
   assign do_push           = push && q_stat.push_ready;
   assign do_pop            = pop && q_stat.pop_valid;
   assign head_desc         = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap and track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries; payload needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/bpf_back.sv
// Back end: serializes queued items into framed bytes and keeps the checksum.
`timescale 1ns / 1ps
`default_nettype none

module bpf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         start_byte,
   input  wire bpf_pkg::desc_type  head_desc,
   input  wire bpf_pkg::qstat_type q_stat,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_is_checksum,
   output logic                    rsp_rejected,
   output logic                    rsp_last_of_run
);
   import bpf_pkg::*;

   // Byte positions within a header run, and of the checksum in a data run
   localparam logic [2:0] STEP_START  = 3'd0;
   localparam logic [2:0] STEP_DEVICE = 3'd1;
   localparam logic [2:0] STEP_SOURCE = 3'd2;
   localparam logic [2:0] STEP_CMD    = 3'd3;
   localparam logic [2:0] STEP_LEN_HI = 3'd4;
   localparam logic [2:0] STEP_LEN_LO = 3'd5;
   localparam logic [2:0] STEP_HDR_CHK = 3'd6;
   localparam logic [2:0] STEP_DATA_CHK = 3'd1;

   logic [2:0] step_ff, step_in;
   logic [7:0] sum_ff, sum_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       chk_ff, chk_in;
   logic       rej_ff, rej_in;
   logic       last_ff, last_in;

   logic       advance, fire;
   logic [2:0] last_step;
   logic [7:0] byte_sel;
   logic [7:0] checksum;
   logic       sel_chk;

   assign advance  = !valid_ff || !rsp_stall;
   assign fire     = advance && q_stat.pop_valid;
   assign checksum = 8'd0 - sum_ff;

   // Pick this cycle's byte from the head item
   always_comb begin
      byte_sel  = 8'd0;
      sel_chk   = 1'b0;
      last_step = 3'd0;
      unique case (head_desc.kind)
         KIND_HEADER: begin
            last_step = head_desc.close ? STEP_HDR_CHK : STEP_LEN_LO;
            unique case (step_ff)
               STEP_START:  byte_sel = start_byte;
               STEP_DEVICE: byte_sel = head_desc.device_id;
               STEP_SOURCE: byte_sel = head_desc.source_id;
               STEP_CMD:    byte_sel = head_desc.packet_command;
               STEP_LEN_HI: byte_sel = head_desc.payload_length[15:8];
               STEP_LEN_LO: byte_sel = head_desc.payload_length[7:0];
               default: begin
                  byte_sel = checksum;
                  sel_chk  = 1'b1;
               end
            endcase
         end
         KIND_DATA: begin
            last_step = head_desc.close ? STEP_DATA_CHK : STEP_START;
            if (step_ff == STEP_DATA_CHK) begin
               byte_sel = checksum;
               sel_chk  = 1'b1;
            end else begin
               byte_sel = head_desc.data_byte;
            end
         end
         default: begin
            last_step = STEP_START;
         end
      endcase
   end

   assign pop = fire && (step_ff == last_step);

   // Load the output register, step through the item, accumulate the sum
   always_comb begin
      step_in  = step_ff;
      sum_in   = sum_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      chk_in   = chk_ff;
      rej_in   = rej_ff;
      last_in  = last_ff;
      if (fire) begin
         valid_in = 1'b1;
         byte_in  = byte_sel;
         chk_in   = sel_chk;
         rej_in   = (head_desc.kind == KIND_REJECT);
         last_in  = (step_ff == last_step);
         step_in  = (step_ff == last_step) ? STEP_START : step_ff + 3'd1;
         if (head_desc.kind == KIND_HEADER && step_ff == STEP_START) begin
            sum_in = start_byte;
         end else if (!sel_chk && head_desc.kind != KIND_REJECT) begin
            sum_in = sum_ff + byte_sel;
         end
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_START;
         sum_ff   <= 8'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      chk_ff  <= chk_in;
      rej_ff  <= rej_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_is_checksum = chk_ff;
   assign rsp_rejected    = rej_ff;
   assign rsp_last_of_run = last_ff;

endmodule

`default_nettype wire

FILE: hdl/bus_packet_framer_checksum_unit.sv
// Top level of the bus packet framer with two's complement checksum.
`timescale 1ns / 1ps
`default_nettype none

// Frames header and payload items into a byte stream, one byte per result
// transfer. A header item yields the start byte, device id, source id,
// command, length MSB and LSB, plus the checksum when the length is zero;
// each data item yields its byte, plus the checksum after the last one.
// A data item with no open packet yields one rejected zero byte. The
// front end takes one item per cycle while the queue of QUEUE_DEPTH items
// has room; the serializer in the back end sends one byte per cycle while
// the result side does not stall, so a header item yields 6 or 7 bytes, a
// data item 1 or 2 and a rejected item 1. csr_wr_data sets the start
// byte; write it only while idle.

module bus_packet_framer_checksum_unit #(
   parameter int QUEUE_DEPTH = bpf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_device_id,
   input  wire logic [7:0]  req_source_id,
   input  wire logic [7:0]  req_packet_command,
   input  wire logic [15:0] req_payload_length,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_checksum,
   output logic             rsp_rejected,
   output logic             rsp_last_of_run
);
   import bpf_pkg::*;

   logic [7:0] start_byte_ff;
   logic [7:0] start_byte_in;
   desc_type   push_desc;
   desc_type   head_desc;
   qstat_type  q_stat;
   logic       push;
   logic       pop;

   // Hold the start byte register
   assign start_byte_in = csr_wr_en ? csr_wr_data : start_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= 8'd0;
      end else begin
         start_byte_ff <= start_byte_in;
      end
   end

   bpf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_device_id      (req_device_id),
      .req_source_id      (req_source_id),
      .req_packet_command (req_packet_command),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .q_stat             (q_stat),
      .push               (push),
      .push_desc          (push_desc)
   );

   bpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_stat    (q_stat)
   );

   bpf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .start_byte      (start_byte_ff),
      .head_desc       (head_desc),
      .q_stat          (q_stat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_checksum (rsp_is_checksum),
      .rsp_rejected    (rsp_rejected),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // A rejected byte is a lone zero result that closes its run
   a_reject_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |->
         rsp_out_byte == 8'd0 && !rsp_is_checksum && rsp_last_of_run)
      else $error("rejected result malformed");

   // A checksum always ends the run of its item
   a_checksum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_checksum |-> rsp_last_of_run)
      else $error("checksum not last of run");

   // Nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The serializer never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.pop_valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: dv/tb_bus_packet_framer_checksum_unit.sv
// Self-checking testbench for the bus packet framer with two's complement checksum.
`timescale 1ns / 1ps

module tb_bus_packet_framer_checksum_unit;

   // Item kinds on the request channel
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   // Cycles without any transfer before the run is declared hung
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Longest sender gap in cycles
   localparam int unsigned MAX_GAP = 40;

   typedef struct {
      logic        command;
      logic [7:0]  device_id;
      logic [7:0]  source_id;
      logic [7:0]  packet_command;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } framer_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       is_checksum;
      logic       rejected;
      logic       last_of_run;
   } frame_byte_type;

   // Predicts the framed byte stream and checks the bytes that come out
   class frame_scoreboard;
      logic [7:0]  start_byte;
      logic [7:0]  running_sum;
      logic [15:0] bytes_left;
      logic        packet_open;
      frame_byte_type expected_bytes[$];
      int unsigned n_errors;

      function new();
         start_byte  = 8'h00;
         running_sum = 8'h00;
         bytes_left  = 16'h0000;
         packet_open = 1'b0;
         n_errors    = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic chk, logic rej, logic last);
         frame_byte_type e;
         e.out_byte    = b;
         e.is_checksum = chk;
         e.rejected    = rej;
         e.last_of_run = last;
         expected_bytes.push_back(e);
      endfunction

      // Add a byte to the packet sum and queue it
      function void send_framed(logic [7:0] b, logic last);
         running_sum = running_sum + b;
         push_byte(b, 1'b0, 1'b0, last);
      endfunction

      // Close the packet with the negated low byte of the sum
      function void close_packet();
         logic [7:0] chk;
         chk = 8'h00 - running_sum;
         push_byte(chk, 1'b1, 1'b0, 1'b1);
         packet_open = 1'b0;
         bytes_left  = 16'h0000;
      endfunction

      function void note_input(framer_item_type it);
         if (it.command == CMD_HEADER) begin
            // a header always starts a fresh packet, dropping any open one
            running_sum = 8'h00;
            send_framed(start_byte, 1'b0);
            send_framed(it.device_id, 1'b0);
            send_framed(it.source_id, 1'b0);
            send_framed(it.packet_command, 1'b0);
            send_framed(it.payload_length[15:8], 1'b0);
            send_framed(it.payload_length[7:0], it.payload_length != 16'h0000);
            if (it.payload_length == 16'h0000) begin
               close_packet();
            end else begin
               bytes_left  = it.payload_length;
               packet_open = 1'b1;
            end
         end else if (!packet_open) begin
            // stray payload byte: flagged, state untouched
            push_byte(8'h00, 1'b0, 1'b1, 1'b1);
         end else begin
            send_framed(it.data_byte, bytes_left != 16'd1);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'h0000) close_packet();
         end
      endfunction

      function void check_result(frame_byte_type got);
         frame_byte_type want;
         if (expected_bytes.size() == 0) begin
            n_errors++;
            $error("unexpected result transfer: out_byte %0h", got.out_byte);
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            n_errors++;
            $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
         end
         if (got.is_checksum !== want.is_checksum) begin
            n_errors++;
            $error("is_checksum: expected %0b, actual %0b", want.is_checksum, got.is_checksum);
         end
         if (got.rejected !== want.rejected) begin
            n_errors++;
            $error("rejected: expected %0b, actual %0b", want.rejected, got.rejected);
         end
         if (got.last_of_run !== want.last_of_run) begin
            n_errors++;
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_HEADER;
   logic [7:0]  req_device_id = 8'h00;
   logic [7:0]  req_source_id = 8'h00;
   logic [7:0]  req_packet_command = 8'h00;
   logic [15:0] req_payload_length = 16'h0000;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_checksum;
   logic        rsp_rejected;
   logic        rsp_last_of_run;

   int unsigned send_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned idle_cycles = 0;

   frame_scoreboard board = new();

   bus_packet_framer_checksum_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_device_id      (req_device_id),
      .req_source_id      (req_source_id),
      .req_packet_command (req_packet_command),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_is_checksum    (rsp_is_checksum),
      .rsp_rejected       (rsp_rejected),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Take result transfers and draw the next stall
   always @(posedge clock) begin : rsp_side
      frame_byte_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte    = rsp_out_byte;
         got.is_checksum = rsp_is_checksum;
         got.rejected    = rsp_rejected;
         got.last_of_run = rsp_last_of_run;
         board.check_result(got);
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Offer one item after a random gap and hold it until the transfer
   task automatic send_item(input framer_item_type it);
      int unsigned n_gap;
      n_gap = 0;
      while (n_gap < MAX_GAP && $urandom_range(0, 99) < send_gap_pct) n_gap++;
      if (n_gap > 0) begin
         req_valid <= 1'b0;
         repeat (n_gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= it.command;
      req_device_id      <= it.device_id;
      req_source_id      <= it.source_id;
      req_packet_command <= it.packet_command;
      req_payload_length <= it.payload_length;
      req_data_byte      <= it.data_byte;
      do @(posedge clock); while (req_stall);
      board.note_input(it);
   endtask

   task automatic send_header(input logic [7:0] dev, input logic [7:0] src,
                              input logic [7:0] pcmd, input logic [15:0] len);
      framer_item_type it;
      it.command        = CMD_HEADER;
      it.device_id      = dev;
      it.source_id      = src;
      it.packet_command = pcmd;
      it.payload_length = len;
      it.data_byte      = 8'($urandom);
      send_item(it);
   endtask

   task automatic send_data(input logic [7:0] b);
      framer_item_type it;
      it.command        = CMD_DATA;
      it.device_id      = 8'($urandom);
      it.source_id      = 8'($urandom);
      it.packet_command = 8'($urandom);
      it.payload_length = 16'($urandom);
      it.data_byte      = b;
      send_item(it);
   endtask

   // Hold off the sender until every expected byte has come out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Write the start byte while the block is idle
   task automatic set_start_byte(input logic [7:0] value);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.start_byte = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      // stray byte straight after reset
      send_data(8'hFF);
      // empty packet, all-zero header
      send_header(8'h00, 8'h00, 8'h00, 16'h0000);
      // widest length, abandoned by the next header
      send_header(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
      send_data(8'h00);
      send_data(8'hFF);
      send_header(8'h01, 8'h02, 8'h03, 16'h0001);
      send_data(8'h80);
      // length with only the upper byte set, abandoned after two bytes
      send_header(8'h5A, 8'hA5, 8'h3C, 16'h0100);
      send_data(8'h11);
      send_data(8'h22);
      send_header(8'hC3, 8'h3C, 8'h7E, 16'h0002);
      send_data(8'hFE);
      send_data(8'h01);
      // stray byte after a closed packet
      send_data(8'h55);
      // empty packet, all-ones header
      send_header(8'hFF, 8'hFF, 8'hFF, 16'h0000);
   endtask

   task automatic run_random(input int unsigned n_target);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      int unsigned n_data;
      sent = 0;
      while (sent < n_target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // complete packet with a short payload
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            send_header(8'($urandom), 8'($urandom), 8'($urandom), 16'(len));
            repeat (len) send_data(8'($urandom));
            sent += len + 1;
         end else if (pick < 85) begin
            // lone payload byte, rejected unless a packet was left open
            send_data(8'($urandom));
            sent++;
         end else if (pick < 97) begin
            // truncated packet, later dropped by a header
            len    = $urandom_range(4, 16'hFFFF);
            n_data = $urandom_range(0, 3);
            send_header(8'($urandom), 8'($urandom), 8'($urandom), 16'(len));
            repeat (n_data) send_data(8'($urandom));
            sent += n_data + 1;
         end else begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct  = 34;
      rsp_stall_pct = 87;
      set_start_byte(8'hFF);
      run_directed();
      set_start_byte(8'h00);
      run_random(115);

      send_gap_pct  = 87;
      rsp_stall_pct = 34;
      set_start_byte(8'($urandom));
      run_random(115);

      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      set_start_byte(8'($urandom));
      run_random(115);

      drain();
      repeat (10) @(posedge clock);
      if (board.n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
